### rtl/core/lues_pkg.sv
// Package for the least used endpoint selector.
// Holds the operation and status codes, the sequencer state type and parameter defaults.
// Depends on nothing.
`timescale 1ns / 1ps

package lues_pkg;

	localparam int MAX_ENDPOINTS_DEF = 16;
	localparam int KEY_BITS_DEF      = 16;
	localparam int COUNT_BITS_DEF    = 16;

	// Width of the key and count fields on the ports.
	localparam int PORT_KEY_W   = 16;
	localparam int PORT_COUNT_W = 16;

	typedef enum logic [1:0] {
		FN_ADD     = 2'd0,
		FN_ACQUIRE = 2'd1,
		FN_RELEASE = 2'd2,
		FN_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_DUPLICATE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_LAST = 2'd2,
		S_DONE = 2'd3
	} seq_state_t;

endpackage

### rtl/core/least_used_endpoint_selector.sv
// Least used endpoint selector: a table of endpoint keys with use counts, kept in
// one synchronous memory and scanned one slot per cycle. Depends on lues_pkg.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  in        in         in_valid / in_ready   func, key
//  out       out        out_valid / out_ready chosen_key, use_count, status
//
// Add, acquire and release take the beat, read the memory once per slot in S_SCAN,
// compare the last slot read in S_LAST and write back in S_DONE. Clear goes from
// S_IDLE straight to S_DONE. The memory read port, which serves one slot per cycle,
// sets the length of the scan.
// Reset clears the valid bits, the sequencer and the output valid flag at once; the key
// and count memory is not cleared, since only valid slots are ever used.
// A result waits in the output register while the next beat is taken and scanned; the
// write-back stalls only if that register is still full when the next result is ready.

module least_used_endpoint_selector #(
	parameter int MAX_ENDPOINTS = lues_pkg::MAX_ENDPOINTS_DEF,
	parameter int KEY_BITS      = lues_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS    = lues_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [lues_pkg::PORT_KEY_W-1:0]   key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lues_pkg::PORT_KEY_W-1:0]   chosen_key,
	output logic [lues_pkg::PORT_COUNT_W-1:0] use_count,
	output logic [2:0]                        status
);
	import lues_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ENDPOINTS);
	localparam int WORD_W = KEY_BITS + COUNT_BITS;

	// Sequencer and the operation under way.
	seq_state_t            state_q, state_d;
	func_t                 func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      idx_q;

	// Key and count memory with its read pipeline.
	logic [WORD_W-1:0]     mem [MAX_ENDPOINTS];
	logic [WORD_W-1:0]     rd_data_s1;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [KEY_BITS-1:0]   rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;

	logic [MAX_ENDPOINTS-1:0] valid_q;

	// Scan results: the matching or least used slot, and the lowest free slot.
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [KEY_BITS-1:0]   hit_key_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	// Output register.
	logic                    out_valid_q;
	logic [PORT_KEY_W-1:0]   out_key_q;
	logic [PORT_COUNT_W-1:0] out_cnt_q;
	status_t                 out_status_q;

	// Write-back decisions, formed in the combinational block.
	logic                    accept;
	logic                    finish;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [WORD_W-1:0]       wr_data;
	logic                    set_valid;
	logic                    clr_all;
	logic [COUNT_BITS-1:0]   new_cnt;
	logic [PORT_KEY_W-1:0]   res_key;
	logic [PORT_COUNT_W-1:0] res_cnt;
	status_t                 res_status;
	logic                    slot_v;
	logic                    take_hit;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	assign rd_key = rd_data_s1[WORD_W-1:COUNT_BITS];
	assign rd_cnt = rd_data_s1[COUNT_BITS-1:0];
	assign slot_v = valid_q[rd_idx_s1];

	// Acquire keeps the first valid slot with a strictly lower count; add and release
	// keep the first valid slot whose key matches.
	always_comb begin
		if (func_q == FN_ACQUIRE) begin
			take_hit = slot_v && (!hit_q || (rd_cnt < hit_cnt_q));
		end else begin
			take_hit = slot_v && !hit_q && (rd_key == key_q);
		end
	end

	// Next state and write-back.
	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = hit_idx_q;
		wr_data    = {hit_key_q, hit_cnt_q};
		set_valid  = 1'b0;
		clr_all    = 1'b0;
		new_cnt    = hit_cnt_q;
		res_key    = PORT_KEY_W'(key_q);
		res_cnt    = '0;
		res_status = ST_OK;

		unique case (func_q)
			FN_ADD: begin
				if (hit_q) begin
					res_status = ST_DUPLICATE;
				end else if (!free_q) begin
					res_status = ST_FULL;
				end else begin
					wr_en     = 1'b1;
					set_valid = 1'b1;
					wr_addr   = free_idx_q;
					wr_data   = {key_q, {COUNT_BITS{1'b0}}};
				end
			end
			FN_ACQUIRE: begin
				if (!hit_q) begin
					res_status = ST_EMPTY;
				end else begin
					// The count saturates at its largest value.
					if (hit_cnt_q != {COUNT_BITS{1'b1}}) begin
						new_cnt = hit_cnt_q + COUNT_BITS'(1);
					end
					wr_en   = 1'b1;
					wr_data = {hit_key_q, new_cnt};
					res_key = PORT_KEY_W'(hit_key_q);
					res_cnt = PORT_COUNT_W'(new_cnt);
				end
			end
			FN_RELEASE: begin
				if (!hit_q) begin
					res_status = ST_NOT_FOUND;
				end else begin
					// Release of an idle endpoint leaves its count at zero.
					if (hit_cnt_q != '0) begin
						new_cnt = hit_cnt_q - COUNT_BITS'(1);
					end
					wr_en   = 1'b1;
					wr_data = {hit_key_q, new_cnt};
					res_cnt = PORT_COUNT_W'(new_cnt);
				end
			end
			FN_CLEAR: begin
				clr_all = 1'b1;
			end
		endcase

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (func_t'(func) == FN_CLEAR) ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (idx_q == IDX_W'(MAX_ENDPOINTS - 1)) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase

		if (!finish) begin
			wr_en     = 1'b0;
			set_valid = 1'b0;
			clr_all   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Memory: one write port for the write-back, one read port for the scan.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[idx_q];
	end

	// Operation registers and scan address.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			key_q  <= KEY_BITS'(key);
		end
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_key_q  <= '0;
			hit_cnt_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (accept) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (state_q == S_SCAN) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (rd_vld_s1) begin
					if (take_hit) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						hit_key_q <= rd_key;
						hit_cnt_q <= rd_cnt;
					end
					if (!slot_v && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
				end
			end
		end
	end

	// Valid bits: set by an add, cleared all at once by a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else if (set_valid) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_key_q    <= res_key;
			out_cnt_q    <= res_cnt;
			out_status_q <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign chosen_key = out_key_q;
	assign use_count  = out_cnt_q;
	assign status     = out_status_q;

endmodule
